// ===== rtl/bfc_pkg.sv =====
// ----------------------------------------------------------------------------
// bfc_pkg
// Shared types and constants of the boundary face classifier: command and
// face class codes, register indexes, stream field layout, control states.
// ----------------------------------------------------------------------------
`default_nettype none

package bfc_pkg;

  // Field widths of the stream items
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned VERT_W  = 20;
  localparam int unsigned TYPE_W  = 8;
  localparam int unsigned PROC_W  = 8;
  localparam int unsigned CLS_W   = 2;
  localparam int unsigned TCNT_W  = 9;

  // Input tdata: vert_a, vert_b, type_id, owner_proc (lowest first)
  localparam int unsigned IN_VA_LSB    = 0;
  localparam int unsigned IN_VB_LSB    = IN_VA_LSB + VERT_W;
  localparam int unsigned IN_TYPE_LSB  = IN_VB_LSB + VERT_W;
  localparam int unsigned IN_OWNER_LSB = IN_TYPE_LSB + TYPE_W;
  localparam int unsigned IN_FIELDS_W  = IN_OWNER_LSB + PROC_W;
  localparam int unsigned IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;

  // Output tdata: face_class, bc_type, type_error, table_full, distinct_types
  localparam int unsigned OUT_FIELDS_W = CLS_W + TYPE_W + 1 + 1 + TCNT_W;
  localparam int unsigned OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_PROC   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RSV_LOCAL    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RSV_PARALLEL = 2'd2;

  localparam logic [CFG_DATA_W-1:0] RSV_LOCAL_RESET    = 8'd0;
  localparam logic [CFG_DATA_W-1:0] RSV_PARALLEL_RESET = 8'd1;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_LOAD     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLASSIFY = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR    = 2'd2;

  // Face class codes
  localparam logic [CLS_W-1:0] CLS_LOCAL    = 2'd0;
  localparam logic [CLS_W-1:0] CLS_PARALLEL = 2'd1;
  localparam logic [CLS_W-1:0] CLS_USER     = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

// ===== rtl/bfc_ram.sv =====
// ----------------------------------------------------------------------------
// bfc_ram
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module bfc_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/boundary_face_classifier_core.sv =====
// ----------------------------------------------------------------------------
// boundary_face_classifier_core
// Loads a table of boundary surfaces and classifies element faces against it.
// ----------------------------------------------------------------------------
// One item is handled at a time. A load or a classify item walks the stored
// surface table through the single read port of the surface RAM, one entry
// per cycle. The scan covers the whole table on a miss and runs up to the
// first hit otherwise, at most MAX_SURFACES entries. A load into a full
// table, a classify of a face owned by another process, a clear and an
// unused command skip the scan. Every item then passes the done state,
// which hands its result to the output register once that register is free,
// and the block takes the next item when back in idle.
// The table needs no clearing pass: the fill count marks the valid entries,
// so the block takes items right after reset. Each item gives exactly one
// result; a finished result waits in the output register while the next
// item is already being taken. Write configuration only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module boundary_face_classifier_core #(
  parameter int unsigned MAX_SURFACES = 256,
  parameter int unsigned VERTEX_BITS  = 20
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,

  // Input stream
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // tdata: vert_a[19:0], vert_b[39:20], type_id[47:40], owner_proc[55:48]
  input  wire logic [bfc_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // tuser: cmd[1:0]
  input  wire logic [bfc_pkg::CMD_W-1:0]       s_axis_tuser,

  // Result stream
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // tdata: face_class[1:0], bc_type[9:2], type_error[10], table_full[11],
  //        distinct_types[20:12], zero fill above
  output logic      [bfc_pkg::OUT_DATA_W-1:0]  m_axis_tdata,

  // Configuration write channel
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [bfc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [bfc_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  // Stored vertex width: the port carries VERT_W bits, compare on the low
  // VERTEX_BITS of them (all VERT_W of them if VERTEX_BITS is larger).
  localparam int unsigned VW = (VERTEX_BITS < bfc_pkg::VERT_W) ? VERTEX_BITS
                                                               : bfc_pkg::VERT_W;
  localparam int unsigned TW = bfc_pkg::TYPE_W;
  localparam int unsigned EW = 2 * VW + TW;           // entry: {type, hi, lo}
  localparam int unsigned AW = (MAX_SURFACES > 1) ? $clog2(MAX_SURFACES) : 1;
  localparam int unsigned CW = $clog2(MAX_SURFACES + 1);
  localparam int unsigned NW = bfc_pkg::TCNT_W;
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_SURFACES);
  localparam logic [CW-1:0] CNT_ONE = CW'(1);

  // --------------------------------------------------------------------------
  // Configuration registers: always ready, unknown indexes are dropped
  // --------------------------------------------------------------------------
  logic [bfc_pkg::CFG_DATA_W-1:0] local_proc_q, rsv_local_q, rsv_par_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_proc_q <= '0;
      rsv_local_q  <= bfc_pkg::RSV_LOCAL_RESET;
      rsv_par_q    <= bfc_pkg::RSV_PARALLEL_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        bfc_pkg::CFG_LOCAL_PROC:   local_proc_q <= cfg_data_i;
        bfc_pkg::CFG_RSV_LOCAL:    rsv_local_q  <= cfg_data_i;
        bfc_pkg::CFG_RSV_PARALLEL: rsv_par_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Input unpacking and vertex ordering
  // --------------------------------------------------------------------------
  logic [bfc_pkg::CMD_W-1:0]  in_cmd;
  logic [VW-1:0]              in_va, in_vb, in_lo, in_hi;
  logic [TW-1:0]              in_type;
  logic [bfc_pkg::PROC_W-1:0] in_owner;

  assign in_cmd   = s_axis_tuser;
  assign in_va    = s_axis_tdata[bfc_pkg::IN_VA_LSB +: VW];
  assign in_vb    = s_axis_tdata[bfc_pkg::IN_VB_LSB +: VW];
  assign in_type  = s_axis_tdata[bfc_pkg::IN_TYPE_LSB +: TW];
  assign in_owner = s_axis_tdata[bfc_pkg::IN_OWNER_LSB +: bfc_pkg::PROC_W];
  assign in_lo    = (in_va <= in_vb) ? in_va : in_vb;
  assign in_hi    = (in_va <= in_vb) ? in_vb : in_va;

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  bfc_pkg::state_e st_q, st_d;

  logic [CW-1:0] surf_count_q;          // fill count, marks valid entries
  logic [NW-1:0] type_count_q;
  logic [CW-1:0] rd_ptr_q;              // next entry to read
  logic          rd_vld_q;              // read data valid this cycle
  logic          rd_last_q;             // ... and it is the last stored entry

  // Item held during the scan
  logic [bfc_pkg::CMD_W-1:0] cmd_q;
  logic [VW-1:0]             lo_q, hi_q;
  logic [TW-1:0]             type_q;

  // Result being built
  logic [bfc_pkg::CLS_W-1:0] res_cls_q;
  logic [TW-1:0]             res_bct_q;
  logic                      res_terr_q, res_full_q;

  // Output register
  logic                      m_tvalid_q;
  logic [bfc_pkg::CLS_W-1:0] out_cls_q;
  logic [TW-1:0]             out_bct_q;
  logic                      out_terr_q, out_full_q;
  logic [NW-1:0]             out_types_q;

  // --------------------------------------------------------------------------
  // Surface RAM
  // --------------------------------------------------------------------------
  logic          mem_we, mem_re;
  logic [EW-1:0] mem_wdata, mem_rdata;
  logic [VW-1:0] rd_lo, rd_hi;
  logic [TW-1:0] rd_type;

  assign mem_wdata = {type_q, hi_q, lo_q};
  assign rd_lo     = mem_rdata[VW-1:0];
  assign rd_hi     = mem_rdata[2*VW-1:VW];
  assign rd_type   = mem_rdata[EW-1:2*VW];

  bfc_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_SURFACES)
  ) u_surf_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (surf_count_q[AW-1:0]),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (rd_ptr_q[AW-1:0]),
    .rdata_o (mem_rdata)
  );

  // --------------------------------------------------------------------------
  // Scan control
  // --------------------------------------------------------------------------
  logic in_xfer, out_free, tbl_full;
  logic hit, scan_empty, scan_end;

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_tvalid_q || m_axis_tready;
  assign tbl_full = surf_count_q >= CNT_MAX;

  // Loads look for the type, classifies for the unordered vertex pair
  assign hit = rd_vld_q && ((cmd_q == bfc_pkg::CMD_LOAD) ? (rd_type == type_q)
                                                         : (rd_lo == lo_q && rd_hi == hi_q));
  // Empty table: nothing issued and nothing in flight
  assign scan_empty = !rd_vld_q && (rd_ptr_q == surf_count_q);
  assign scan_end   = scan_empty || hit || (rd_vld_q && rd_last_q);

  // Next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      bfc_pkg::ST_IDLE: begin
        if (in_xfer) begin
          if ((in_cmd == bfc_pkg::CMD_LOAD && !tbl_full) ||
              (in_cmd == bfc_pkg::CMD_CLASSIFY && in_owner == local_proc_q)) begin
            st_d = bfc_pkg::ST_SCAN;
          end else begin
            st_d = bfc_pkg::ST_DONE;
          end
        end
      end
      bfc_pkg::ST_SCAN: begin
        if (scan_end) st_d = bfc_pkg::ST_DONE;
      end
      bfc_pkg::ST_DONE: begin
        if (out_free) st_d = bfc_pkg::ST_IDLE;
      end
      default: st_d = bfc_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the controller
  always_comb begin
    s_axis_tready = 1'b0;
    mem_re        = 1'b0;
    mem_we        = 1'b0;
    case (st_q)
      bfc_pkg::ST_IDLE: s_axis_tready = 1'b1;
      bfc_pkg::ST_SCAN: begin
        // Stream reads until the end of the table or until a hit shows up
        mem_re = (rd_ptr_q < surf_count_q) && !scan_end;
        // Append the surface once the type search is over
        mem_we = scan_end && (cmd_q == bfc_pkg::CMD_LOAD);
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q         <= bfc_pkg::ST_IDLE;
      surf_count_q <= '0;
      type_count_q <= '0;
      rd_ptr_q     <= '0;
      rd_vld_q     <= 1'b0;
      rd_last_q    <= 1'b0;
      m_tvalid_q   <= 1'b0;
    end else begin
      st_q      <= st_d;
      rd_vld_q  <= mem_re;
      rd_last_q <= mem_re && ((rd_ptr_q + CNT_ONE) == surf_count_q);

      if (in_xfer) begin
        rd_ptr_q <= '0;
      end else if (mem_re) begin
        rd_ptr_q <= rd_ptr_q + CNT_ONE;
      end

      if (in_xfer && in_cmd == bfc_pkg::CMD_CLEAR) begin
        surf_count_q <= '0;
        type_count_q <= '0;
      end else if (mem_we) begin
        surf_count_q <= surf_count_q + CNT_ONE;
        if (!hit) type_count_q <= type_count_q + NW'(1);
      end

      // Hand the finished result to the output register, drop it on transfer
      if (st_q == bfc_pkg::ST_DONE && out_free) begin
        m_tvalid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_tvalid_q <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Payload registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      cmd_q      <= in_cmd;
      lo_q       <= in_lo;
      hi_q       <= in_hi;
      type_q     <= in_type;
      res_bct_q  <= '0;
      res_cls_q  <= (in_cmd == bfc_pkg::CMD_CLASSIFY && in_owner != local_proc_q)
                    ? bfc_pkg::CLS_PARALLEL : bfc_pkg::CLS_LOCAL;
      res_terr_q <= (in_cmd == bfc_pkg::CMD_LOAD) &&
                    (in_type == rsv_local_q || in_type == rsv_par_q);
      res_full_q <= (in_cmd == bfc_pkg::CMD_LOAD) && tbl_full;
    end else if (st_q == bfc_pkg::ST_SCAN && hit && cmd_q == bfc_pkg::CMD_CLASSIFY) begin
      res_cls_q <= bfc_pkg::CLS_USER;
      res_bct_q <= rd_type;
    end

    if (st_q == bfc_pkg::ST_DONE && out_free) begin
      out_cls_q   <= res_cls_q;
      out_bct_q   <= res_bct_q;
      out_terr_q  <= res_terr_q;
      out_full_q  <= res_full_q;
      out_types_q <= type_count_q;
    end
  end

  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = {(bfc_pkg::OUT_DATA_W - bfc_pkg::OUT_FIELDS_W)'(0),
                          out_types_q, out_full_q, out_terr_q, out_bct_q, out_cls_q};

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    surf_count_q <= CNT_MAX)
    else $error("surface count beyond table depth");

  a_types_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CW'(type_count_q) <= surf_count_q)
    else $error("more distinct types than stored surfaces");

  a_read_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> st_q == bfc_pkg::ST_SCAN)
    else $error("read data arrives outside a scan");

  a_xfer_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> st_q != bfc_pkg::ST_IDLE)
    else $error("accepted item did not start work");

  a_parallel_no_type: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_q && out_cls_q == bfc_pkg::CLS_PARALLEL) |-> out_bct_q == '0)
    else $error("parallel face carries a type");

endmodule

`default_nettype wire
